// ===== hw/rtl/replacement_selection_runs_defines.svh =====
// ----------------------------------------------------------------------------
// Replacement selection run generator: assertion macros
// Concurrent check macros clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef REPLACEMENT_SELECTION_RUNS_DEFINES_SVH
`define REPLACEMENT_SELECTION_RUNS_DEFINES_SVH

`ifndef SYNTHESIS
// implication or plain property that must hold at every edge
`define RSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// condition that must never be seen
`define RSR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define RSR_ASSERT(lbl, prop, msg)
`define RSR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Replacement selection run generator: package
// Sizes, result codes and the structs passed between the sequencer and the
// shared selection unit.
// ----------------------------------------------------------------------------
package rsr_pkg;

  localparam int unsigned SLOTS    = 8;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned PAY_BITS = 16;
  localparam int unsigned RUN_BITS = 16;
  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);

  localparam logic [RUN_BITS-1:0] RUN_FIRST = RUN_BITS'(1);
  localparam logic [RUN_BITS-1:0] RUN_MAX   = {RUN_BITS{1'b1}};

  // result kind codes
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic        [PAY_BITS-1:0] pay_t;
  typedef logic        [IDX_W-1:0]    idx_t;

  // one slot presented to the selection unit
  typedef struct packed {
    logic full;
    logic next_run;
    idx_t idx;
    key_t key;
    pay_t pay;
  } rsr_cand_t;

  // sequencer control for the selection unit
  typedef struct packed {
    logic step;
    logic first;
  } rsr_sel_ctrl_t;

  // running winner held by the selection unit
  typedef struct packed {
    logic valid;
    logic next_run;
    idx_t idx;
    key_t key;
    pay_t pay;
  } rsr_best_t;

endpackage

// ===== hw/rtl/rsr_slots.sv =====
// ----------------------------------------------------------------------------
// Replacement selection run generator: slot store
// Record key and payload per slot; one write port, one read port.
// ----------------------------------------------------------------------------
module rsr_slots (
  input  logic          clk_i,
  input  logic          we_i,
  input  rsr_pkg::idx_t widx_i,
  input  rsr_pkg::key_t wkey_i,
  input  rsr_pkg::pay_t wpay_i,
  input  rsr_pkg::idx_t ridx_i,
  output rsr_pkg::key_t rkey_o,
  output rsr_pkg::pay_t rpay_o
);

  rsr_pkg::key_t key_q [rsr_pkg::SLOTS];
  rsr_pkg::pay_t pay_q [rsr_pkg::SLOTS];

  // contents are undefined until written, so no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_q[widx_i] <= wkey_i;
      pay_q[widx_i] <= wpay_i;
    end
  end

  assign rkey_o = key_q[ridx_i];
  assign rpay_o = pay_q[ridx_i];

endmodule

// ===== hw/rtl/rsr_sel.sv =====
// ----------------------------------------------------------------------------
// Replacement selection run generator: selection unit
// One (run, key) comparator that folds one slot per step into the winner.
// ----------------------------------------------------------------------------
module rsr_sel (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rsr_pkg::rsr_sel_ctrl_t ctrl_i,
  input  rsr_pkg::rsr_cand_t     cand_i,
  output rsr_pkg::rsr_best_t     best_o
);

  rsr_pkg::rsr_best_t best_q, best_d;
  logic               better;

  // strict compare keeps the lower slot on ties
  always_comb begin
    better = (!cand_i.next_run && best_q.next_run) ||
             ((cand_i.next_run == best_q.next_run) && (cand_i.key < best_q.key));
  end

  always_comb begin
    best_d = best_q;
    if (ctrl_i.step) begin
      if (ctrl_i.first) begin
        best_d.valid    = cand_i.full;
        best_d.next_run = cand_i.next_run;
        best_d.idx      = cand_i.idx;
        best_d.key      = cand_i.key;
        best_d.pay      = cand_i.pay;
      end else if (cand_i.full && (!best_q.valid || better)) begin
        best_d.valid    = 1'b1;
        best_d.next_run = cand_i.next_run;
        best_d.idx      = cand_i.idx;
        best_d.key      = cand_i.key;
        best_d.pay      = cand_i.pay;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

// ===== hw/rtl/replacement_selection_runs.sv =====
// ----------------------------------------------------------------------------
// Replacement selection run generator
// Builds sorted runs for external sorting by replacement selection over eight
// record slots ordered by (run, key), ties to the lower slot. The first eight
// records of a file only fill slots. Every later record is accepted, then
// the single comparator walks the slots one per cycle, then a decide step
// and an emit step follow; the block puts out an end-of-run marker when the
// winner opens the next run, then the winner, and its slot takes the new
// record. A record flagged last then flushes the slots and closes with a
// final marker, after which the block is empty again. Results wait in one
// output register, so output stalls only hold the sequencer at its emit
// steps. Markers carry zero key and payload and the run they end; run numbers
// start at one and saturate at 65535. final_res_o flags the last beat caused
// by one input record.
// ----------------------------------------------------------------------------
`include "replacement_selection_runs_defines.svh"

module replacement_selection_runs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           key_i,
  input  logic        [15:0]           payload_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         kind_o,
  output logic signed [15:0]           out_key_o,
  output logic        [15:0]           out_payload_o,
  output logic        [15:0]           run_index_o,
  output logic                         final_res_o
);

  // one-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_MARK  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FINAL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // held input record
  rsr_pkg::key_t key_q, key_d;
  rsr_pkg::pay_t pay_q, pay_d;
  logic          last_q, last_d;
  logic          flush_q, flush_d;

  // slot bookkeeping
  logic [rsr_pkg::SLOTS-1:0]    full_q, full_d;
  logic [rsr_pkg::SLOTS-1:0]    nr_q, nr_d;
  logic [rsr_pkg::CNT_W-1:0]    fill_q, fill_d;
  logic [rsr_pkg::RUN_BITS-1:0] run_q, run_d;
  rsr_pkg::idx_t                idx_q, idx_d;

  // output register
  logic                         ov_q, ov_d;
  logic                         okind_q, okind_d;
  rsr_pkg::key_t                okey_q, okey_d;
  rsr_pkg::pay_t                opay_q, opay_d;
  logic [rsr_pkg::RUN_BITS-1:0] orun_q, orun_d;
  logic                         ofin_q, ofin_d;

  // slot store ports
  logic          slot_we;
  rsr_pkg::idx_t slot_widx;
  rsr_pkg::key_t slot_wkey;
  rsr_pkg::pay_t slot_wpay;
  rsr_pkg::key_t slot_rkey;
  rsr_pkg::pay_t slot_rpay;

  // selection unit
  rsr_pkg::rsr_sel_ctrl_t sel_ctrl;
  rsr_pkg::rsr_cand_t     sel_cand;
  rsr_pkg::rsr_best_t     best;

  logic in_fire;
  logic emit_ok;
  logic filling;
  logic [rsr_pkg::RUN_BITS-1:0] run_inc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // output register free, or emptied on this edge
  assign emit_ok    = !ov_q || out_ready_i;
  assign filling    = (fill_q < rsr_pkg::CNT_W'(rsr_pkg::SLOTS));
  assign run_inc    = (run_q == rsr_pkg::RUN_MAX) ? run_q : run_q + 1'b1;

  rsr_slots u_slots (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .widx_i (slot_widx),
    .wkey_i (slot_wkey),
    .wpay_i (slot_wpay),
    .ridx_i (idx_q),
    .rkey_o (slot_rkey),
    .rpay_o (slot_rpay)
  );

  // present the scanned slot to the comparator
  always_comb begin
    sel_cand.full     = full_q[idx_q];
    sel_cand.next_run = nr_q[idx_q];
    sel_cand.idx      = idx_q;
    sel_cand.key      = slot_rkey;
    sel_cand.pay      = slot_rpay;
    sel_ctrl.step     = (state_q == S_SCAN);
    sel_ctrl.first    = (idx_q == '0);
  end

  rsr_sel u_sel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sel_ctrl),
    .cand_i (sel_cand),
    .best_o (best)
  );

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    pay_d     = pay_q;
    last_d    = last_q;
    flush_d   = flush_q;
    full_d    = full_q;
    nr_d      = nr_q;
    fill_d    = fill_q;
    run_d     = run_q;
    idx_d     = idx_q;
    ov_d      = ov_q && !out_ready_i;
    okind_d   = okind_q;
    okey_d    = okey_q;
    opay_d    = opay_q;
    orun_d    = orun_q;
    ofin_d    = ofin_q;
    slot_we   = 1'b0;
    slot_widx = best.idx;
    slot_wkey = key_q;
    slot_wpay = pay_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          key_d  = key_i;
          pay_d  = payload_i;
          last_d = last_i;
          idx_d  = '0;
          if (filling) begin
            // fill the next free slot in the current run
            slot_we   = 1'b1;
            slot_widx = fill_q[rsr_pkg::IDX_W-1:0];
            slot_wkey = key_i;
            slot_wpay = payload_i;
            full_d[fill_q[rsr_pkg::IDX_W-1:0]] = 1'b1;
            nr_d[fill_q[rsr_pkg::IDX_W-1:0]]   = 1'b0;
            fill_d  = fill_q + 1'b1;
            flush_d = last_i;
            if (last_i) begin
              state_d = S_SCAN;
            end
          end else begin
            flush_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // advance one slot per cycle through the comparator
        idx_d = idx_q + 1'b1;
        if (idx_q == rsr_pkg::IDX_W'(rsr_pkg::SLOTS - 1)) begin
          state_d = S_MARK;
        end
      end

      S_MARK: begin
        if (!best.valid) begin
          state_d = S_FINAL;
        end else if (!best.next_run) begin
          state_d = S_EMIT;
        end else if (emit_ok) begin
          // winner opens the next run: close the current one first
          ov_d    = 1'b1;
          okind_d = rsr_pkg::KIND_MARKER;
          okey_d  = '0;
          opay_d  = '0;
          orun_d  = run_q;
          ofin_d  = 1'b0;
          run_d   = run_inc;
          nr_d    = '0;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (emit_ok) begin
          ov_d    = 1'b1;
          okind_d = rsr_pkg::KIND_RECORD;
          okey_d  = best.key;
          opay_d  = best.pay;
          orun_d  = run_q;
          ofin_d  = !flush_q && !last_q;
          idx_d   = '0;
          if (flush_q) begin
            // drop the flushed slot
            full_d[best.idx] = 1'b0;
            state_d = S_SCAN;
          end else begin
            // replace the winner; a key below it waits for the next run
            slot_we = 1'b1;
            nr_d[best.idx] = (key_q < best.key);
            if (last_q) begin
              flush_d = 1'b1;
              state_d = S_SCAN;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end

      S_FINAL: begin
        if (emit_ok) begin
          ov_d    = 1'b1;
          okind_d = rsr_pkg::KIND_MARKER;
          okey_d  = '0;
          opay_d  = '0;
          orun_d  = run_q;
          ofin_d  = 1'b1;
          // return to empty
          full_d  = '0;
          nr_d    = '0;
          fill_d  = '0;
          run_d   = rsr_pkg::RUN_FIRST;
          flush_d = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
      flush_q <= 1'b0;
      full_q  <= '0;
      nr_q    <= '0;
      fill_q  <= '0;
      run_q   <= rsr_pkg::RUN_FIRST;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      flush_q <= flush_d;
      full_q  <= full_d;
      nr_q    <= nr_d;
      fill_q  <= fill_d;
      run_q   <= run_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers hold without reset
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    pay_q   <= pay_d;
    okind_q <= okind_d;
    okey_q  <= okey_d;
    opay_q  <= opay_d;
    orun_q  <= orun_d;
    ofin_q  <= ofin_d;
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = okind_q;
  assign out_key_o     = okey_q;
  assign out_payload_o = opay_q;
  assign run_index_o   = orun_q;
  assign final_res_o   = ofin_q;

  // checks
  `RSR_ASSERT(a_steady_all_full, (state_q == S_IDLE && !filling) |-> (&full_q), "slot empty in steady state")
  `RSR_ASSERT_NEVER(a_run_zero, (run_q == '0), "run number reached zero")
  `RSR_ASSERT(a_marker_blank, (ov_q && okind_q == rsr_pkg::KIND_MARKER) |-> (okey_q == '0 && opay_q == '0), "marker carries data")

endmodule
